/* sv/bdll_pkg.sv */
// Package for the bounded doubly linked list: field widths, default capacity
// and action codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bdll_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int ACTION_W     = 3;

  localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SEARCH    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd4;

endpackage
`default_nettype wire

/* sv/bdll_in_if.sv */
// Input channel of the linked list: valid/ready plus action and value.
// Depends on bdll_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bdll_in_if;
  logic                                valid;
  logic                                ready;
  logic        [bdll_pkg::ACTION_W-1:0] action;
  logic signed [bdll_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface
`default_nettype wire

/* sv/bdll_out_if.sv */
// Result channel of the linked list: valid/ready plus ok flag and count.
// Depends on bdll_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bdll_out_if #(
  parameter int CNT_W = $clog2(bdll_pkg::CAPACITY_DEF + 1)
);
  logic             valid;
  logic             ready;
  logic             ok;
  logic [CNT_W-1:0] count;

  modport source (output valid, output ok, output count, input ready);
  modport sink   (input valid, input ok, input count, output ready);
endinterface
`default_nettype wire

/* sv/bdll_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bdll_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/bounded_doubly_linked_list.sv */
// Bounded doubly linked list: top level with sequencer and node memories.
// Depends on bdll_pkg, bdll_in_if, bdll_out_if and bdll_ram.
`timescale 1ns / 1ps
`default_nettype none
// Keeps an ordered list of up to CAPACITY signed 32-bit values. Each item is
// insert front, insert back, remove first match from the head, search, or
// clear, and yields one result: ok and the count after the action. One item
// is worked on at a time; in_ready is high only while the sequencer is idle.
// From acceptance: clear, unknown actions, inserts into a full list and
// walks of an empty list go straight to RESP; an insert passes through ALLOC
// (for a freed slot), INS1 and, unless the list was empty, INS2; remove and
// search visit one node per WALK step (at most CAPACITY) by one registered
// RAM read through the value/link memories feeding a single compare. The
// next item is accepted the cycle after the result is loaded, even while
// that result waits on out_ready. Freed slots go on a free stack and fresh
// slots come from a high-water mark, so reset and clear need no memory sweep.
module bounded_doubly_linked_list #(
  parameter int CAPACITY = bdll_pkg::CAPACITY_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bdll_in_if.sink     in_ch,
  bdll_out_if.source  out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int VW = bdll_pkg::VALUE_W;
  localparam logic [LW-1:0] NULL_L = LW'(CAPACITY);
  localparam logic [LW-1:0] ONE_L  = LW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_INS1,
    ST_INS2,
    ST_WALK,
    ST_RESP
  } state_t;

  state_t                         state_r, state_nxt;
  logic [LW-1:0]                  head_r, head_nxt;
  logic [LW-1:0]                  tail_r, tail_nxt;
  logic [LW-1:0]                  count_r, count_nxt;
  logic [LW-1:0]                  sp_r, sp_nxt;
  logic [LW-1:0]                  wm_r, wm_nxt;
  logic [bdll_pkg::ACTION_W-1:0]  act_r, act_nxt;
  logic [VW-1:0]                  value_r, value_nxt;
  logic [AW-1:0]                  slot_r, slot_nxt;
  logic [AW-1:0]                  cur_r, cur_nxt;
  logic                           res_ok_r, res_ok_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_ok_r, out_ok_nxt;
  logic [LW-1:0]                  out_count_r, out_count_nxt;

  // node memories share one read address
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] val_rdata;
  logic [LW-1:0] next_rdata, prev_rdata;
  logic          val_we, next_we, prev_we;
  logic [AW-1:0] val_waddr, next_waddr, prev_waddr;
  logic [LW-1:0] next_wdata, prev_wdata;

  logic          free_we;
  logic [AW-1:0] free_waddr, free_raddr, free_rdata;

  logic          hit;

  bdll_ram #(.W(VW), .D(CAPACITY)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(value_r),
    .raddr(rd_addr), .rdata(val_rdata)
  );

  bdll_ram #(.W(LW), .D(CAPACITY)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(rd_addr), .rdata(next_rdata)
  );

  bdll_ram #(.W(LW), .D(CAPACITY)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(rd_addr), .rdata(prev_rdata)
  );

  bdll_ram #(.W(AW), .D(CAPACITY)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(cur_r),
    .raddr(free_raddr), .rdata(free_rdata)
  );

  // the shared compare
  assign hit = (val_rdata == value_r);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.ok    = out_ok_r;
  assign out_ch.count = out_count_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    sp_nxt        = sp_r;
    wm_nxt        = wm_r;
    act_nxt       = act_r;
    value_nxt     = value_r;
    slot_nxt      = slot_r;
    cur_nxt       = cur_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ok_nxt    = out_ok_r;
    out_count_nxt = out_count_r;

    rd_addr    = cur_r;
    val_we     = 1'b0;
    val_waddr  = slot_r;
    next_we    = 1'b0;
    next_waddr = slot_r;
    next_wdata = NULL_L;
    prev_we    = 1'b0;
    prev_waddr = slot_r;
    prev_wdata = NULL_L;
    free_we    = 1'b0;
    free_waddr = sp_r[AW-1:0];
    free_raddr = AW'(sp_r - ONE_L);

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          act_nxt    = in_ch.action;
          value_nxt  = in_ch.value;
          res_ok_nxt = 1'b0;
          state_nxt  = ST_RESP;
          case (in_ch.action)
            bdll_pkg::ACT_INS_FRONT, bdll_pkg::ACT_INS_BACK: begin
              if (count_r != NULL_L) begin
                if (sp_r != '0) begin
                  state_nxt = ST_ALLOC;
                end else begin
                  slot_nxt  = wm_r[AW-1:0];
                  wm_nxt    = wm_r + ONE_L;
                  state_nxt = ST_INS1;
                end
              end
            end
            bdll_pkg::ACT_REMOVE, bdll_pkg::ACT_SEARCH: begin
              if (head_r != NULL_L) begin
                rd_addr   = head_r[AW-1:0];
                cur_nxt   = head_r[AW-1:0];
                state_nxt = ST_WALK;
              end
            end
            bdll_pkg::ACT_CLEAR: begin
              head_nxt   = NULL_L;
              tail_nxt   = NULL_L;
              count_nxt  = '0;
              sp_nxt     = '0;
              wm_nxt     = '0;
              res_ok_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_ALLOC: begin
        slot_nxt  = free_rdata;
        sp_nxt    = sp_r - ONE_L;
        state_nxt = ST_INS1;
      end

      ST_INS1: begin
        val_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        if (head_r == NULL_L) begin
          head_nxt   = LW'(slot_r);
          tail_nxt   = LW'(slot_r);
          count_nxt  = count_r + ONE_L;
          res_ok_nxt = 1'b1;
          state_nxt  = ST_RESP;
        end else begin
          if (act_r == bdll_pkg::ACT_INS_FRONT) begin
            next_wdata = head_r;
          end else begin
            prev_wdata = tail_r;
          end
          state_nxt = ST_INS2;
        end
      end

      ST_INS2: begin
        // hook the old end node to the new one
        if (act_r == bdll_pkg::ACT_INS_FRONT) begin
          prev_we    = 1'b1;
          prev_waddr = head_r[AW-1:0];
          prev_wdata = LW'(slot_r);
          head_nxt   = LW'(slot_r);
        end else begin
          next_we    = 1'b1;
          next_waddr = tail_r[AW-1:0];
          next_wdata = LW'(slot_r);
          tail_nxt   = LW'(slot_r);
        end
        count_nxt  = count_r + ONE_L;
        res_ok_nxt = 1'b1;
        state_nxt  = ST_RESP;
      end

      ST_WALK: begin
        if (hit) begin
          res_ok_nxt = 1'b1;
          state_nxt  = ST_RESP;
          if (act_r == bdll_pkg::ACT_REMOVE) begin
            // unlink cur: prev_rdata/next_rdata are its links
            if (prev_rdata != NULL_L) begin
              next_we    = 1'b1;
              next_waddr = prev_rdata[AW-1:0];
              next_wdata = next_rdata;
            end else begin
              head_nxt = next_rdata;
            end
            if (next_rdata != NULL_L) begin
              prev_we    = 1'b1;
              prev_waddr = next_rdata[AW-1:0];
              prev_wdata = prev_rdata;
            end else begin
              tail_nxt = prev_rdata;
            end
            free_we   = 1'b1;
            sp_nxt    = sp_r + ONE_L;
            count_nxt = count_r - ONE_L;
          end
        end else if (next_rdata == NULL_L) begin
          res_ok_nxt = 1'b0;
          state_nxt  = ST_RESP;
        end else begin
          rd_addr = next_rdata[AW-1:0];
          cur_nxt = next_rdata[AW-1:0];
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_count_nxt = count_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= NULL_L;
      tail_r      <= NULL_L;
      count_r     <= '0;
      sp_r        <= '0;
      wm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      sp_r        <= sp_nxt;
      wm_r        <= wm_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r       <= act_nxt;
    value_r     <= value_nxt;
    slot_r      <= slot_nxt;
    cur_r       <= cur_nxt;
    res_ok_r    <= res_ok_nxt;
    out_ok_r    <= out_ok_nxt;
    out_count_r <= out_count_nxt;
  end

  // slots handed out minus slots on the free stack equals the count
  a_slot_books: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((wm_r - sp_r) == count_r))
    else $error("slot accounting out of step with count");

  a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((head_r == NULL_L) == (count_r == '0)))
    else $error("head null disagrees with count");

  a_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((tail_r == NULL_L) == (head_r == NULL_L)))
    else $error("head and tail disagree on empty list");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NULL_L)
    else $error("count beyond capacity");

endmodule
`default_nettype wire
